// File: sv/ctg_pkg.sv
`timescale 1ns / 1ps

package ctg_pkg;

  // Register widths and reset values.
  localparam int OnSamplesW  = 20;
  localparam int OffSamplesW = 20;
  localparam int PhaseStepW  = 31;
  localparam int AmplitudeW  = 15;
  localparam int CycleW      = 21;
  localparam int PhaseW      = 32;
  localparam int SampleW     = 16;
  localparam int CfgDataW    = 31;

  localparam logic [OnSamplesW-1:0]  OnSamplesRst  = 20'd8000;
  localparam logic [OffSamplesW-1:0] OffSamplesRst = 20'd24000;
  localparam logic [PhaseStepW-1:0]  PhaseStepRst  = 31'd236223201;
  localparam logic [AmplitudeW-1:0]  AmplitudeRst  = 15'd9830;

  // pi/2 in Q30.
  localparam logic [63:0] HalfPiQ30 = 64'd1686629713;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_ON_SAMPLES  = 2'd0,
    CFG_OFF_SAMPLES = 2'd1,
    CFG_PHASE_STEP  = 2'd2,
    CFG_AMPLITUDE   = 2'd3
  } cfg_idx_e;

  // Quarter-wave sine entry k for a table of 2^table_bits entries, evaluated at
  // elaboration. Taylor series to x^13 in Q30 with truncated products.
  function automatic logic [15:0] sine_entry(input int k, input int table_bits);
    logic [63:0] a;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] v;
    a    = ((64'(k) * 64'd2 + 64'd1) * HalfPiQ30) >> (table_bits + 1);
    term = a;
    sum  = a;
    for (int n = 1; n <= 6; n++) begin
      term = (term * a) >> 30;
      term = (term * a) >> 30;
      case (n)
        1:       term = term / 64'd6;
        2:       term = term / 64'd20;
        3:       term = term / 64'd42;
        4:       term = term / 64'd72;
        5:       term = term / 64'd110;
        default: term = term / 64'd156;
      endcase
      if ((n % 2) == 1) begin
        sum = (sum >= term) ? sum - term : 64'd0;
      end else begin
        sum = sum + term;
      end
    end
    v = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[15:0];
  endfunction

endpackage

// File: sv/cadenced_tone_generator_unit.sv
// A result passes through stage one and then the output register after its input
// transfer, and can transfer out once the output register holds it.
// Throughput: one sample per cycle while out_ready_i holds; the position/phase
// update sits at the input stage and the amplitude multiply at the output stage.
// Reset: position and phase clear to zero, the registers take their default
// cadence (8000 on, 24000 off, 440 Hz step, 0.3 level), and both stages empty.
`timescale 1ns / 1ps

module cadenced_tone_generator_unit #(
  parameter int COUNT_BITS      = 21,
  parameter int SINE_TABLE_BITS = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Sample tick channel
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              restart_i,
  // Result channel
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [ctg_pkg::SampleW-1:0] sample_o,
  output logic                              tone_on_o,
  // Configuration write channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [1:0]                        cfg_index_i,
  input  logic [ctg_pkg::CfgDataW-1:0]      cfg_data_i
);

  localparam int TableSize = 1 << SINE_TABLE_BITS;
  localparam int CmpW = (COUNT_BITS > ctg_pkg::CycleW) ? COUNT_BITS : ctg_pkg::CycleW;

  // Configuration registers.
  logic [ctg_pkg::OnSamplesW-1:0]  on_samples_q;
  logic [ctg_pkg::OffSamplesW-1:0] off_samples_q;
  logic [ctg_pkg::PhaseStepW-1:0]  phase_step_q;
  logic [ctg_pkg::AmplitudeW-1:0]  amplitude_q;

  // Cadence state.
  logic [COUNT_BITS-1:0]      pos_q, pos_d;
  logic [ctg_pkg::PhaseW-1:0] phase_q, phase_d;

  // Stage registers.
  logic        s1_valid_q;
  logic [15:0] mag_q;
  logic        neg_q;
  logic        s1_on_q;
  logic        out_valid_q;
  logic signed [ctg_pkg::SampleW-1:0] sample_q;
  logic        tone_on_q;

  logic in_xfer;
  logic out_adv;
  logic s1_adv;

  logic [ctg_pkg::CycleW-1:0]  cycle_len;
  logic [COUNT_BITS-1:0]       base_pos, pos_cur, pos_inc;
  logic [ctg_pkg::PhaseW-1:0]  base_phase, phase_cur;
  logic                        tone_on;
  logic [1:0]                  quad;
  logic [SINE_TABLE_BITS-1:0]  tab_idx;
  logic [15:0]                 tab_mag;
  logic [30:0]                 prod;
  logic [15:0]                 prod_mag;
  logic signed [ctg_pkg::SampleW-1:0] sample_d;

  logic [15:0] sine_rom [TableSize];

  // Quarter-wave sine table, constant after elaboration.
  for (genvar k = 0; k < TableSize; k++) begin : g_sine_rom
    localparam logic [15:0] Entry = ctg_pkg::sine_entry(k, SINE_TABLE_BITS);
    assign sine_rom[k] = Entry;
  end

  // Handshake: the output register frees stage one, which frees the input.
  assign out_adv     = !out_valid_q || out_ready_i;
  assign s1_adv      = !s1_valid_q || out_adv;
  assign in_ready_o  = s1_adv;
  assign in_xfer     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  // Configuration writes; every index names a register, extra data bits are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_samples_q  <= ctg_pkg::OnSamplesRst;
      off_samples_q <= ctg_pkg::OffSamplesRst;
      phase_step_q  <= ctg_pkg::PhaseStepRst;
      amplitude_q   <= ctg_pkg::AmplitudeRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (ctg_pkg::cfg_idx_e'(cfg_index_i))
        ctg_pkg::CFG_ON_SAMPLES:  on_samples_q  <= cfg_data_i[ctg_pkg::OnSamplesW-1:0];
        ctg_pkg::CFG_OFF_SAMPLES: off_samples_q <= cfg_data_i[ctg_pkg::OffSamplesW-1:0];
        ctg_pkg::CFG_PHASE_STEP:  phase_step_q  <= cfg_data_i[ctg_pkg::PhaseStepW-1:0];
        ctg_pkg::CFG_AMPLITUDE:   amplitude_q   <= cfg_data_i[ctg_pkg::AmplitudeW-1:0];
        default: ;
      endcase
    end
  end

  // Cadence position and phase for the sample being accepted.
  always_comb begin
    cycle_len  = ctg_pkg::CycleW'(on_samples_q) + ctg_pkg::CycleW'(off_samples_q);
    base_pos   = restart_i ? '0 : pos_q;
    base_phase = restart_i ? '0 : phase_q;
    // A position left beyond the cycle by a register write starts a new cycle.
    pos_cur    = (CmpW'(base_pos) >= CmpW'(cycle_len)) ? '0 : base_pos;
    phase_cur  = (pos_cur == '0) ? '0 : base_phase;
    tone_on    = (cycle_len != '0) && (CmpW'(pos_cur) < CmpW'(on_samples_q));
    pos_inc    = pos_cur + COUNT_BITS'(1);
    if (cycle_len == '0) begin
      pos_d   = '0;
      phase_d = '0;
    end else begin
      pos_d   = (CmpW'(pos_inc) >= CmpW'(cycle_len)) ? '0 : pos_inc;
      phase_d = tone_on ? phase_cur + ctg_pkg::PhaseW'(phase_step_q) : phase_cur;
    end
  end

  // Quadrant fold into the quarter-wave table.
  always_comb begin
    quad    = phase_cur[31:30];
    tab_idx = phase_cur[29 -: SINE_TABLE_BITS];
    if (quad[0]) begin
      tab_idx = ~tab_idx;
    end
    tab_mag = sine_rom[tab_idx];
  end

  // Scale by amplitude, truncating the magnitude toward zero.
  always_comb begin
    prod     = 31'(mag_q) * 31'(amplitude_q);
    prod_mag = prod[30:15];
    if (!s1_on_q) begin
      sample_d = '0;
    end else if (neg_q) begin
      sample_d = -$signed(prod_mag);
    end else begin
      sample_d = $signed(prod_mag);
    end
  end

  // Cadence state advances on each input transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      phase_q <= '0;
    end else if (in_xfer) begin
      pos_q   <= pos_d;
      phase_q <= phase_d;
    end
  end

  // Stage one: table magnitude and sign.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_adv) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      mag_q   <= tone_on ? tab_mag : '0;
      neg_q   <= quad[1];
      s1_on_q <= tone_on;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv && s1_valid_q) begin
      sample_q  <= sample_d;
      tone_on_q <= s1_on_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign sample_o    = sample_q;
  assign tone_on_o   = tone_on_q;

  // A silent sample is exactly zero.
  a_off_is_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !tone_on_o) |-> (sample_o == '0))
    else $error("nonzero sample in the off part");

  // The input stalls only when both stages hold a result.
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_valid_q && out_valid_q))
    else $error("input stalled with a free stage");

  // An empty cadence leaves position and phase at zero.
  a_empty_cycle_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && (on_samples_q == '0) && (off_samples_q == '0))
      |=> ((pos_q == '0) && (phase_q == '0)))
    else $error("state not cleared on empty cadence");

  // A restart with a tone part starts the phase over from one step.
  a_restart_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && restart_i && (on_samples_q != '0))
      |=> (phase_q == ctg_pkg::PhaseW'($past(phase_step_q))))
    else $error("phase after restart is not one step");

endmodule

// File: tb/cadenced_tone_generator_unit_test.sv
`timescale 1ns / 1ps

module cadenced_tone_generator_unit_test;

  localparam int TableBits = 8;
  localparam int QuarterLen = 1 << TableBits;
  localparam int unsigned PosMask = (1 << ctg_pkg::CycleW) - 1;
  localparam int unsigned CycleLimit = 400_000;
  localparam int TargetTicks = 1800;

  // One expected output transfer.
  typedef struct {
    logic signed [ctg_pkg::SampleW-1:0] sample;
    logic                               tone_on;
  } tone_result_t;

  // Tracks the cadence position, the phase and the registers, and holds the
  // samples the block still owes.
  class tone_cadence_model;
    logic [ctg_pkg::OnSamplesW-1:0]  on_len;
    logic [ctg_pkg::OffSamplesW-1:0] off_len;
    logic [ctg_pkg::PhaseStepW-1:0]  step;
    logic [ctg_pkg::AmplitudeW-1:0]  level;
    logic [ctg_pkg::CycleW-1:0]      position;
    logic [ctg_pkg::PhaseW-1:0]      phase;
    logic [15:0]                     quarter_wave[QuarterLen];
    tone_result_t                    expected_samples[$];
    int                              errors;
    int                              checked;
    int                              tone_samples;

    function new();
      on_len       = ctg_pkg::OnSamplesRst;
      off_len      = ctg_pkg::OffSamplesRst;
      step         = ctg_pkg::PhaseStepRst;
      level        = ctg_pkg::AmplitudeRst;
      position     = '0;
      phase        = '0;
      errors       = 0;
      checked      = 0;
      tone_samples = 0;
      for (int k = 0; k < QuarterLen; k++) begin
        quarter_wave[k] = quarter_wave_point(k);
      end
    endfunction

    // Sine at the middle of table slot k, Taylor series in Q30 with every
    // product and division truncated, then scaled to Q1.15 with rounding.
    function logic [15:0] quarter_wave_point(int k);
      longint unsigned x;
      longint unsigned term;
      longint unsigned acc;
      longint unsigned scaled;
      x    = (longint'(2 * k + 1) * ctg_pkg::HalfPiQ30) >> (TableBits + 1);
      term = x;
      acc  = x;
      for (int n = 1; n <= 6; n++) begin
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = term / longint'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) begin
          acc = (acc >= term) ? acc - term : 0;
        end else begin
          acc = acc + term;
        end
      end
      scaled = (acc * 32767 + (64'd1 << 29)) >> 30;
      if (scaled > 32767) begin
        scaled = 32767;
      end
      return scaled[15:0];
    endfunction

    // The top two phase bits pick the quadrant; odd quadrants mirror the
    // index and the second half of the turn is negative.
    function int sine_at(logic [ctg_pkg::PhaseW-1:0] ph);
      logic [TableBits-1:0] idx;
      int                   mag;
      idx = ph[29 -: TableBits];
      if (ph[30]) begin
        idx = ~idx;
      end
      mag = int'(quarter_wave[idx]);
      return ph[31] ? -mag : mag;
    endfunction

    function void set_register(logic [1:0] idx, logic [ctg_pkg::CfgDataW-1:0] data);
      case (ctg_pkg::cfg_idx_e'(idx))
        ctg_pkg::CFG_ON_SAMPLES:  on_len  = data[ctg_pkg::OnSamplesW-1:0];
        ctg_pkg::CFG_OFF_SAMPLES: off_len = data[ctg_pkg::OffSamplesW-1:0];
        ctg_pkg::CFG_PHASE_STEP:  step    = data[ctg_pkg::PhaseStepW-1:0];
        ctg_pkg::CFG_AMPLITUDE:   level   = data[ctg_pkg::AmplitudeW-1:0];
        default: ;
      endcase
    endfunction

    // Advances the cadence by one sample tick and queues the sample it makes.
    function void take_tick(logic restart);
      tone_result_t r;
      int unsigned  cyc;
      int unsigned  pos;
      int unsigned  nxt;
      int unsigned  mag;
      int unsigned  prod;
      int           s;
      r.sample  = '0;
      r.tone_on = 1'b0;
      cyc = int'(on_len) + int'(off_len);
      if (restart) begin
        position = '0;
        phase    = '0;
      end
      if (cyc == 0) begin
        position = '0;
        phase    = '0;
      end else begin
        // A register write may have left the position past the cycle end.
        pos = 32'(position);
        if (pos >= cyc) begin
          pos = 0;
        end
        if (pos == 0) begin
          phase = '0;
        end
        if (pos < on_len) begin
          s    = sine_at(phase);
          mag  = (s < 0) ? -s : s;
          prod = (mag * level) >> 15;
          r.sample  = ctg_pkg::SampleW'((s < 0) ? -int'(prod) : int'(prod));
          r.tone_on = 1'b1;
          phase     = phase + step;
        end
        nxt = (pos + 1) & PosMask;
        if (nxt >= cyc) begin
          nxt = 0;
        end
        position = nxt[ctg_pkg::CycleW-1:0];
      end
      expected_samples.push_back(r);
    endfunction

    // Prints one line for each mismatch and counts it.
    task report(string msg);
      errors++;
      $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    task check_sample(logic signed [ctg_pkg::SampleW-1:0] got_sample, logic got_on);
      tone_result_t want;
      if (expected_samples.size() == 0) begin
        report($sformatf("sample %0d arrived with none outstanding", got_sample));
        return;
      end
      want = expected_samples.pop_front();
      checked++;
      if (want.tone_on) begin
        tone_samples++;
      end
      if (got_sample !== want.sample) begin
        report($sformatf("sample #%0d: got %0d, want %0d", checked, got_sample,
                         want.sample));
      end
      if (got_on !== want.tone_on) begin
        report($sformatf("tone_on #%0d: got %b, want %b", checked, got_on,
                         want.tone_on));
      end
    endtask

    function int pending();
      return expected_samples.size();
    endfunction
  endclass

  logic                               clk_i;
  logic                               rst_ni       = 1'b0;
  logic                               in_valid_i   = 1'b0;
  logic                               in_ready_o;
  logic                               restart_i    = 1'b0;
  logic                               out_valid_o;
  logic                               out_ready_i  = 1'b1;
  logic signed [ctg_pkg::SampleW-1:0] sample_o;
  logic                               tone_on_o;
  logic                               cfg_valid_i  = 1'b0;
  logic                               cfg_ready_o;
  logic [1:0]                         cfg_index_i  = '0;
  logic [ctg_pkg::CfgDataW-1:0]       cfg_data_i   = '0;

  tone_cadence_model cadence;
  int tx_mode = 0;
  int rx_mode = 0;
  int ticks_sent = 0;
  int restarts = 0;
  int reg_writes = 0;
  int settings = 0;

  cadenced_tone_generator_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .restart_i   (restart_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sample_o    (sample_o),
    .tone_on_o   (tone_on_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Mode 0 never idles, mode 1 may idle before every transfer, and
  // mode 2 idles only now and then.
  function automatic int draw_gap(int mode);
    case (mode)
      0:       return 0;
      1:       return $urandom_range(0, 15);
      default: return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : 0;
    endcase
  endfunction

  // Every transfer on the three channels goes to the model at the clock edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        cadence.set_register(cfg_index_i, cfg_data_i);
      end
      if (in_valid_i && in_ready_o) begin
        cadence.take_tick(restart_i);
      end
      if (out_valid_o && out_ready_i) begin
        cadence.check_sample(sample_o, tone_on_o);
      end
    end
  end

  // The receiver may stall before each transfer, with gaps drawn by its mode.
  initial begin
    int stall;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = draw_gap(rx_mode);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Sends one sample tick. Valid stays high between back-to-back ticks.
  task automatic send_tick(logic restart);
    int gap;
    gap = draw_gap(tx_mode);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    restart_i  <= restart;
    do @(posedge clk_i); while (!in_ready_o);
    ticks_sent++;
    if (restart) begin
      restarts++;
    end
  endtask

  // Ends a burst of ticks and waits until every sample has come back. The
  // first edge lets the monitor note the last input transfer.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (cadence.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(ctg_pkg::cfg_idx_e idx, logic [ctg_pkg::CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    reg_writes++;
  endtask

  // Writes the registers selected in the mask, in index order.
  task automatic set_cadence(logic [ctg_pkg::CfgDataW-1:0] on_len,
                             logic [ctg_pkg::CfgDataW-1:0] off_len,
                             logic [ctg_pkg::CfgDataW-1:0] step,
                             logic [ctg_pkg::CfgDataW-1:0] level,
                             logic [3:0] mask);
    if (mask[ctg_pkg::CFG_ON_SAMPLES])  write_reg(ctg_pkg::CFG_ON_SAMPLES, on_len);
    if (mask[ctg_pkg::CFG_OFF_SAMPLES]) write_reg(ctg_pkg::CFG_OFF_SAMPLES, off_len);
    if (mask[ctg_pkg::CFG_PHASE_STEP])  write_reg(ctg_pkg::CFG_PHASE_STEP, step);
    if (mask[ctg_pkg::CFG_AMPLITUDE])   write_reg(ctg_pkg::CFG_AMPLITUDE, level);
    cfg_valid_i <= 1'b0;
    settings++;
  endtask

  function automatic logic [ctg_pkg::CfgDataW-1:0] pick_length();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 31'h000F_FFFF;
      2, 3:    return ctg_pkg::CfgDataW'($urandom());
      default: return ctg_pkg::CfgDataW'($urandom_range(1, 24));
    endcase
  endfunction

  // Watchdog for a hung handshake.
  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    logic [ctg_pkg::CfgDataW-1:0] step;
    logic [ctg_pkg::CfgDataW-1:0] level;
    int                           count;
    int                           odds;
    cadence = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Default cadence right after reset, with restarts on the first and third ticks.
    tx_mode = 2;
    rx_mode = 2;
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    drain();

    // Short five-sample cycle at full step and full level: wraps after the third
    // sample and leaves the position at three.
    set_cadence(31'd3, 31'd2, 31'h7FFF_FFFF, 31'h7FFF, 4'b1111);
    repeat (6) send_tick(1'b0);
    drain();

    // Shrinking the cycle below the current position starts a new cycle.
    set_cadence(31'd1, 31'd1, '0, '0, 4'b0011);
    repeat (3) send_tick(1'b0);
    drain();

    // Zero cycle length.
    set_cadence('0, '0, '0, '0, 4'b0011);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);
    drain();

    // Silent cadence with zero step and zero level.
    set_cadence('0, 31'h000F_FFFF, '0, '0, 4'b1111);
    send_tick(1'b0);
    send_tick(1'b1);
    drain();

    // Longest cycle with the smallest nonzero step and level.
    set_cadence(31'h000F_FFFF, 31'h000F_FFFF, 31'd1, 31'd1, 4'b1111);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);
    drain();

    // Random cadences, each followed by a burst of ticks and a full drain.
    while (ticks_sent < TargetTicks) begin
      tx_mode = $urandom_range(0, 2);
      rx_mode = $urandom_range(0, 2);
      case ($urandom_range(0, 7))
        0:       step = '0;
        1:       step = 31'h7FFF_FFFF;
        2:       step = ctg_pkg::CfgDataW'($urandom_range(0, 65535));
        default: step = ctg_pkg::CfgDataW'($urandom());
      endcase
      case ($urandom_range(0, 5))
        0:       level = '0;
        1:       level = 31'h7FFF;
        default: level = ctg_pkg::CfgDataW'($urandom());
      endcase
      set_cadence(pick_length(), pick_length(), step, level, 4'($urandom_range(1, 15)));
      count = $urandom_range(30, 120);
      odds  = $urandom_range(4, 64);
      repeat (count) send_tick($urandom_range(0, odds - 1) == 0);
      drain();
    end

    repeat (8) @(posedge clk_i);
    $display("Summary: %0d samples checked, %0d of them in the tone part, %0d restarts.",
             cadence.checked, cadence.tone_samples, restarts);
    $display("Summary: %0d register writes over %0d cadence settings.", reg_writes,
             settings);
    if (cadence.errors == 0 && cadence.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: files.f
sv/ctg_pkg.sv
sv/cadenced_tone_generator_unit.sv
tb/cadenced_tone_generator_unit_test.sv
